### hdl/tls_pkg.sv
// Shared constants and types for the three linked stacks block.
`timescale 1ns / 1ps

package tls_pkg;

	// Store geometry
	localparam int CAPACITY = 128;
	localparam int ENTRY_W  = $clog2(CAPACITY);
	localparam int PTR_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int SEL_W    = 2;
	localparam int STACKS   = 3;

	// A top or link equal to the store size marks "no entry"
	localparam logic [PTR_W-1:0] NULL_MARK = PTR_W'(CAPACITY);
	localparam logic [PTR_W-1:0] FULL_MARK = PTR_W'(CAPACITY);

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Stack select code that names no stack
	localparam logic [SEL_W-1:0] SEL_INVALID = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	// One entry of the shared store
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PTR_W-1:0]  link;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // input beat taken this cycle
		logic load_imm; // load a result that needs no store read
		logic rd_done;  // store read data is valid, finish the pop
	} tls_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pop_hit;  // accepted beat is a pop of a non-empty stack
	} tls_sts_t;

endpackage

### hdl/tls_ctrl.sv
// Controller: input and output handshakes and the pop read sequence.
`timescale 1ns / 1ps

module tls_ctrl import tls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  tls_sts_t sts,
	output tls_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// Take a beat only when idle and the output slot is free or draining
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	assign cmd.accept   = accept;
	assign cmd.load_imm = accept && !sts.pop_hit;
	assign cmd.rd_done  = (state_q == S_READ);

	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && sts.pop_hit) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state, hold result valid until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_imm || cmd.rd_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/tls_dp.sv
// Datapath: shared entry store, stack tops, allocation pointer and result register.
`timescale 1ns / 1ps

module tls_dp import tls_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tls_cmd_t                 cmd,
	output tls_sts_t                 sts,
	input  logic                     opcode,
	input  logic [SEL_W-1:0]         stack_sel,
	input  logic signed [DATA_W-1:0] push_data,
	output logic signed [DATA_W-1:0] pop_data,
	output logic [1:0]               status
);

	entry_t             mem [CAPACITY];
	entry_t             rd_q;
	logic [PTR_W-1:0]   tops_q [STACKS];
	logic [PTR_W-1:0]   alloc_q;
	logic [SEL_W-1:0]   sel_q;
	logic [DATA_W-1:0]  pop_data_q;
	logic [1:0]         status_q;

	logic [PTR_W-1:0]   top_cur;
	logic               sel_ok;
	logic               is_push;
	logic               full;
	logic               empty;
	logic               push_do;
	logic [1:0]         imm_status;

	// Decode the incoming beat
	always_comb begin
		case (stack_sel)
			2'd0:    top_cur = tops_q[0];
			2'd1:    top_cur = tops_q[1];
			2'd2:    top_cur = tops_q[2];
			default: top_cur = NULL_MARK;
		endcase
		sel_ok  = (stack_sel != SEL_INVALID);
		is_push = (opcode == OP_PUSH);
		full    = (alloc_q == FULL_MARK);
		empty   = (top_cur == NULL_MARK);
		push_do = sel_ok && is_push && !full;
		if (!sel_ok) begin
			imm_status = ST_INVALID;
		end else if (is_push) begin
			imm_status = full ? ST_FULL : ST_OK;
		end else begin
			imm_status = ST_EMPTY;
		end
	end

	assign sts.pop_hit = sel_ok && !is_push && !empty;

	// Write the pushed entry at the bump pointer
	always_ff @(posedge clk) begin
		if (cmd.accept && push_do) begin
			mem[alloc_q[ENTRY_W-1:0]] <= '{data: push_data, link: top_cur};
		end
	end

	// Read the top entry of the popped stack
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.pop_hit) begin
			rd_q <= mem[top_cur[ENTRY_W-1:0]];
		end
	end

	// Hold the stack number across the read cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sel_q <= stack_sel;
		end
	end

	// Update stack tops and the allocation pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACKS; i++) begin
				tops_q[i] <= NULL_MARK;
			end
			alloc_q <= '0;
		end else begin
			if (cmd.accept && push_do) begin
				alloc_q <= alloc_q + PTR_W'(1);
			end
			for (int i = 0; i < STACKS; i++) begin
				if (cmd.accept && push_do && stack_sel == SEL_W'(i)) begin
					tops_q[i] <= alloc_q;
				end else if (cmd.rd_done && sel_q == SEL_W'(i)) begin
					tops_q[i] <= rd_q.link;
				end
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			pop_data_q <= '0;
			status_q   <= imm_status;
		end else if (cmd.rd_done) begin
			pop_data_q <= rd_q.data;
			status_q   <= ST_OK;
		end
	end

	assign pop_data = pop_data_q;
	assign status   = status_q;

endmodule

### hdl/three_linked_stacks_shared_store_core.sv
// Top level: three LIFO stacks sharing one linked entry store.
`timescale 1ns / 1ps

// Three stacks share a store of CAPACITY entries, handed out in order and
// never reclaimed, so the store reports full after CAPACITY successful pushes
// in total until reset. Every beat gives exactly one result beat. A push, or
// any beat with an invalid stack, full store or empty stack, loads the result
// register directly; a successful pop first reads the top entry from the
// store's registered read port, then its link becomes the new top. in_ready
// drops during that read cycle and while an earlier result waits on out_ready.
// The store needs no clearing after reset.

module three_linked_stacks_shared_store_core import tls_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic [SEL_W-1:0]         stack_sel,
	input  logic signed [DATA_W-1:0] push_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] pop_data,
	output logic [1:0]               status
);

	tls_cmd_t cmd;
	tls_sts_t sts;

	tls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (opcode),
		.stack_sel (stack_sel),
		.push_data (push_data),
		.pop_data  (pop_data),
		.status    (status)
	);

	// Read data lands only when the output slot is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_done |-> !out_valid)
		else $error("pop read finished while a result was still pending");

	// No new beat while a pop read is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_done |-> !in_ready)
		else $error("input accepted during a pop read");

	// A beat that needs no read shows its result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !sts.pop_hit) |=> out_valid)
		else $error("immediate result not presented");

	// A successful pop presents its result in the cycle after the read
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_done |=> (out_valid && status == ST_OK))
		else $error("pop result not presented after read");

endmodule
